// File: sv/irdpl_pkg.sv
// Shared types, constants and the reset curve of the IR distance linearizer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package irdpl_pkg;

  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 9;
  localparam int DIST_W   = 12;
  localparam int IDX_W    = 5;
  localparam int PTS_W    = 5;

  localparam logic [PTS_W-1:0] PTS_RESET = 5'd17;
  localparam int               PTS_MIN   = 2;

  localparam int SCALE_MUL   = 500;
  localparam int SCALE_SHIFT = 10;
  localparam int PROD_W      = SAMPLE_W + LEVEL_W;

  localparam int DIST_MAX = 4095;

  // interpolation arithmetic: dy (13b signed) * ds (10b signed)
  localparam int DY_W  = DIST_W + 1;
  localparam int DS_W  = LEVEL_W + 1;
  localparam int NUM_W = DY_W + DS_W;
  localparam int MAG_W = 21;            // |dy*ds| <= 4095*511 < 2**21
  localparam int DEN_W = LEVEL_W + 1;
  localparam int DIV_W = LEVEL_W;       // |den| magnitude
  localparam int SUM_W = NUM_W;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_NEAR   = 2'd1,
    ST_FAR    = 2'd2,
    ST_WRITE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_LAST = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] lvl;
    logic [DIST_W-1:0]  distance;
  } point_t;

  typedef struct packed {
    logic    capture;
    logic    write_point;
    rd_sel_e rd_sel;
    logic    save_prev;
    logic    x0_cur;
    logic    x0_prev;
    logic    x1_cur;
    logic    set_near;
    logic    set_far;
    logic    set_zero_den;
    logic    mul;
    logic    div_start;
    logic    set_interp;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic near_hit;
    logic far_hit;
    logic stop;
    logic at_zero;
    logic den_zero;
    logic div_done;
  } sts_t;

  // Reset curve; slots past the table repeat the far point.
  function automatic point_t dflt_point(input int idx);
    point_t p;
    unique case (idx)
      0:       p = '{lvl: 9'd300, distance: 12'd30};
      1:       p = '{lvl: 9'd270, distance: 12'd40};
      2:       p = '{lvl: 9'd235, distance: 12'd50};
      3:       p = '{lvl: 9'd200, distance: 12'd60};
      4:       p = '{lvl: 9'd175, distance: 12'd70};
      5:       p = '{lvl: 9'd155, distance: 12'd80};
      6:       p = '{lvl: 9'd140, distance: 12'd90};
      7:       p = '{lvl: 9'd130, distance: 12'd100};
      8:       p = '{lvl: 9'd110, distance: 12'd120};
      9:       p = '{lvl: 9'd90,  distance: 12'd140};
      10:      p = '{lvl: 9'd80,  distance: 12'd160};
      11:      p = '{lvl: 9'd75,  distance: 12'd180};
      12:      p = '{lvl: 9'd65,  distance: 12'd200};
      13:      p = '{lvl: 9'd50,  distance: 12'd250};
      14:      p = '{lvl: 9'd45,  distance: 12'd300};
      15:      p = '{lvl: 9'd35,  distance: 12'd350};
      default: p = '{lvl: 9'd30,  distance: 12'd400};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: sv/irdpl_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on irdpl_pkg for the operand widths.
`default_nettype none

module irdpl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [irdpl_pkg::MAG_W-1:0] dividend_i,
  input  logic [irdpl_pkg::DIV_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [irdpl_pkg::MAG_W-1:0] quotient_o
);
  import irdpl_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] trial;

  assign rem_sh = {rem_q, quo_q[MAG_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, divisor_i};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(MAG_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (!trial[DIV_W+1]) begin
        rem_d = trial[DIV_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: sv/irdpl_datapath.sv
// Datapath: sample scaling, breakpoint memory, segment registers,
// multiply, divide and result registers. Uses irdpl_pkg and irdpl_div.
`default_nettype none

module irdpl_datapath #(
  parameter int MAX_POINTS = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [irdpl_pkg::PTS_W-1:0]    cfg_data_i,
  input  logic                          operation_i,
  input  logic [irdpl_pkg::SAMPLE_W-1:0] raw_sample_i,
  input  logic [irdpl_pkg::IDX_W-1:0]    point_index_i,
  input  logic [irdpl_pkg::LEVEL_W-1:0]  point_level_i,
  input  logic [irdpl_pkg::DIST_W-1:0]   point_distance_i,
  input  irdpl_pkg::cmd_t               cmd_i,
  output irdpl_pkg::sts_t               sts_o,
  output logic [irdpl_pkg::LEVEL_W-1:0]  scaled_level_o,
  output logic [irdpl_pkg::DIST_W-1:0]   distance_mm_o,
  output logic [1:0]                    status_o
);
  import irdpl_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  // configuration
  logic [PTS_W-1:0] pts_q;
  logic [AW-1:0]    last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q <= PTS_RESET;
    end else if (cfg_we_i) begin
      pts_q <= cfg_data_i;
    end
  end

  always_comb begin
    int n_pts;
    n_pts = int'(pts_q);
    if (n_pts < PTS_MIN) n_pts = PTS_MIN;
    if (n_pts > MAX_POINTS) n_pts = MAX_POINTS;
    last_idx = AW'(n_pts - 1);
  end

  // breakpoint memory; entries never written read as the reset curve
  point_t          mem_q [MAX_POINTS];
  logic [MAX_POINTS-1:0] valid_q;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr, rd_addr_q;
  point_t          rd_data_q;
  logic            rd_vld_q;
  point_t          cur;

  assign wr_en   = cmd_i.write_point && (int'(point_index_i) < MAX_POINTS);
  assign wr_addr = AW'(point_index_i);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_LAST: rd_addr = last_idx;
      RD_NEXT: rd_addr = (rd_addr_q == last_idx) ? rd_addr_q : AW'(rd_addr_q + 1'b1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= '{lvl: point_level_i, distance: point_distance_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) valid_q[wr_addr] <= 1'b1;
      rd_addr_q <= rd_addr;
      rd_vld_q  <= valid_q[rd_addr];
    end
  end

  assign cur = rd_vld_q ? rd_data_q : dflt_point(int'(rd_addr_q));

  // scaled sample, zero for a write item
  logic [PROD_W-1:0]  prod;
  logic [LEVEL_W-1:0] s_q;

  assign prod = PROD_W'(raw_sample_i) * PROD_W'(SCALE_MUL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q <= (operation_i == OP_WRITE) ? '0 : LEVEL_W'(prod >> SCALE_SHIFT);
    end
  end

  // segment end points
  point_t prev_q, x0_q, x1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_prev) prev_q <= cur;
    if (cmd_i.x0_cur) begin
      x0_q <= cur;
    end else if (cmd_i.x0_prev) begin
      x0_q <= prev_q;
    end
    if (cmd_i.x1_cur) x1_q <= cur;
  end

  // (y1-y0)*(s-x0) and x1-x0
  logic signed [DY_W-1:0]  dy;
  logic signed [DS_W-1:0]  ds;
  logic signed [NUM_W-1:0] num_d, num_q;
  logic signed [DEN_W-1:0] den_d, den_q;

  assign dy    = $signed({1'b0, x1_q.distance}) - $signed({1'b0, x0_q.distance});
  assign ds    = $signed({1'b0, s_q}) - $signed({1'b0, x0_q.lvl});
  assign num_d = dy * ds;
  assign den_d = $signed({1'b0, x1_q.lvl}) - $signed({1'b0, x0_q.lvl});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  // divide magnitudes, restore sign: truncation toward zero
  logic [NUM_W-1:0] num_abs;
  logic [DEN_W-1:0] den_abs;
  logic             q_neg;
  logic [MAG_W-1:0] quo;
  logic             div_done;

  assign num_abs = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign den_abs = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
  assign q_neg   = num_q[NUM_W-1] ^ den_q[DEN_W-1];

  irdpl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_abs[MAG_W-1:0]),
    .divisor_i  (den_abs[DIV_W-1:0]),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  logic signed [MAG_W:0]   q_s;
  logic signed [SUM_W-1:0] sum;
  logic [DIST_W-1:0]       interp_dist;

  assign q_s = q_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum = $signed({{(SUM_W-DIST_W){1'b0}}, x0_q.distance})
             + $signed({{(SUM_W-MAG_W-1){q_s[MAG_W]}}, q_s});

  always_comb begin
    if (sum[SUM_W-1]) begin
      interp_dist = '0;
    end else if (sum > $signed(SUM_W'(DIST_MAX))) begin
      interp_dist = DIST_W'(DIST_MAX);
    end else begin
      interp_dist = sum[DIST_W-1:0];
    end
  end

  // result and output registers
  logic [DIST_W-1:0]  res_dist_q;
  status_e            res_status_q;
  logic [LEVEL_W-1:0] out_scaled_q;
  logic [DIST_W-1:0]  out_dist_q;
  status_e            out_status_q;

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.write_point) begin
      res_dist_q   <= '0;
      res_status_q <= ST_WRITE;
    end else if (cmd_i.set_near) begin
      res_dist_q   <= cur.distance;
      res_status_q <= ST_NEAR;
    end else if (cmd_i.set_far) begin
      res_dist_q   <= cur.distance;
      res_status_q <= ST_FAR;
    end else if (cmd_i.set_zero_den) begin
      res_dist_q   <= x0_q.distance;
      res_status_q <= ST_INTERP;
    end else if (cmd_i.set_interp) begin
      res_dist_q   <= interp_dist;
      res_status_q <= ST_INTERP;
    end
    if (cmd_i.load_out) begin
      out_scaled_q <= s_q;
      out_dist_q   <= res_dist_q;
      out_status_q <= res_status_q;
    end
  end

  assign sts_o.near_hit = s_q > cur.lvl;
  assign sts_o.far_hit  = s_q < cur.lvl;
  assign sts_o.stop     = (rd_addr_q == last_idx) || (s_q >= cur.lvl);
  assign sts_o.at_zero  = (rd_addr_q == '0);
  assign sts_o.den_zero = (x1_q.lvl == x0_q.lvl);
  assign sts_o.div_done = div_done;

  assign scaled_level_o = out_scaled_q;
  assign distance_mm_o  = out_dist_q;
  assign status_o       = out_status_q;

endmodule

`default_nettype wire

// File: sv/irdpl_ctrl.sv
// Sequencer: handshakes, clamp checks, segment search walk and divide wait.
// Depends on irdpl_pkg for the command and status structs.
`default_nettype none

module irdpl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            operation_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  irdpl_pkg::sts_t sts_i,
  output irdpl_pkg::cmd_t cmd_o
);
  import irdpl_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_NEAR   = 9'b000000010,
    S_FAR    = 9'b000000100,
    S_SEARCH = 9'b000001000,
    S_SEG1   = 9'b000010000,
    S_MUL    = 9'b000100000,
    S_DIVGO  = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;
  logic   accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.rd_sel = RD_ZERO;
    unique case (state_q)
      S_IDLE: begin
        cmd.capture     = accept;
        cmd.write_point = accept && (operation_i == OP_WRITE);
        if (accept) begin
          state_d = (operation_i == OP_WRITE) ? S_FIN : S_NEAR;
        end
      end
      S_NEAR: begin
        if (sts_i.near_hit) begin
          cmd.set_near = 1'b1;
          state_d      = S_FIN;
        end else begin
          cmd.rd_sel = RD_LAST;
          state_d    = S_FAR;
        end
      end
      S_FAR: begin
        if (sts_i.far_hit) begin
          cmd.set_far = 1'b1;
          state_d     = S_FIN;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.rd_sel    = RD_NEXT;
        cmd.save_prev = 1'b1;
        if (sts_i.stop) begin
          if (sts_i.at_zero) begin
            cmd.x0_cur = 1'b1;
            state_d    = S_SEG1;
          end else begin
            cmd.x0_prev = 1'b1;
            cmd.x1_cur  = 1'b1;
            state_d     = S_MUL;
          end
        end
      end
      S_SEG1: begin
        cmd.x1_cur = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        if (sts_i.den_zero) begin
          cmd.set_zero_den = 1'b1;
          state_d          = S_FIN;
        end else begin
          cmd.mul = 1'b1;
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd.set_interp = 1'b1;
          state_d        = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // one item in flight: no second accept right after the first
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // starting the divider clears its done flag before the wait state
  a_div_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVGO) |=> (state_q == S_DIV) && !sts_i.div_done)
    else $error("stale divider done");

  // clamp results come straight from the two boundary reads
  a_clamp_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.set_near || cmd.set_far) |=> (state_q == S_FIN))
    else $error("clamp did not go to result");

endmodule

`default_nettype wire

// File: sv/ir_distance_piecewise_linearizer_unit.sv
// IR distance linearizer: top level, sequencer plus datapath.
// Depends on irdpl_pkg, irdpl_ctrl, irdpl_datapath (and irdpl_div under it).
//
// Usage:
//  - Input channel in_valid_i/in_ready_o carries one item: operation_i selects
//    convert (raw_sample_i) or breakpoint write (point_index_i, point_level_i,
//    point_distance_i). Output channel out_valid_o/out_ready_i returns one
//    item per input: scaled_level_o, distance_mm_o, status_o.
//  - cfg_we_i/cfg_data_i set the number of breakpoints used (saturated to
//    2..MAX_POINTS); write only while the block is idle.
//  - One item at a time. A write goes straight to the result; a convert
//    checks the near clamp, then the far clamp, then walks the segments
//    (one breakpoint read per cycle from the breakpoint memory) and runs
//    the bit-serial divider. A zero-width segment skips the divide.
//  - The finished result sits in an output register; in_ready_o rises again
//    once it is loaded, so the next item is taken while the result waits.
//    If the receiver stalls, the following result holds in the sequencer
//    until the output register is free.
//  - Reset: the curve reads as the 17-point default at once (valid bits
//    per slot, no clearing pass), point count 17, both channels empty.
`default_nettype none

module ir_distance_piecewise_linearizer_unit #(
  parameter int MAX_POINTS = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [9:0]  raw_sample_i,
  input  logic [4:0]  point_index_i,
  input  logic [8:0]  point_level_i,
  input  logic [11:0] point_distance_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  scaled_level_o,
  output logic [11:0] distance_mm_o,
  output logic [1:0]  status_o
);
  import irdpl_pkg::*;

  cmd_t cmd;   // sequencer -> datapath
  sts_t sts;   // datapath compare results -> sequencer

  irdpl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  irdpl_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .raw_sample_i     (raw_sample_i),
    .point_index_i    (point_index_i),
    .point_level_i    (point_level_i),
    .point_distance_i (point_distance_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .scaled_level_o   (scaled_level_o),
    .distance_mm_o    (distance_mm_o),
    .status_o         (status_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for ir_distance_piecewise_linearizer_unit.
// Depends on irdpl_pkg and the block's RTL; it holds its own curve model
// and checks each item on the output channel against it.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import irdpl_pkg::*;

  localparam int CURVE_SLOTS = 17;      // matches the block's MAX_POINTS default
  localparam int CYCLE_LIMIT = 500000;  // far above the slowest legal run
  localparam int SETTLE      = 60;      // covers the longest interpolation

  // expected contents of one output item
  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [DIST_W-1:0]  distance;
    status_e            status;
  } reading_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [PTS_W-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                operation_i;
  logic [SAMPLE_W-1:0] raw_sample_i;
  logic [IDX_W-1:0]    point_index_i;
  logic [LEVEL_W-1:0]  point_level_i;
  logic [DIST_W-1:0]   point_distance_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [LEVEL_W-1:0]  scaled_level_o;
  logic [DIST_W-1:0]   distance_mm_o;
  logic [1:0]          status_o;

  // model of the breakpoint store and the point count, reset contents
  int               curve_lvl_m  [CURVE_SLOTS] = '{300, 270, 235, 200, 175, 155, 140, 130,
                                                   110, 90, 80, 75, 65, 50, 45, 35, 30};
  int               curve_dist_m [CURVE_SLOTS] = '{30, 40, 50, 60, 70, 80, 90, 100, 120,
                                                   140, 160, 180, 200, 250, 300, 350, 400};
  logic [PTS_W-1:0] point_count_m = PTS_RESET;

  reading_t pending_readings [$];
  int       errors        = 0;
  int       cycles        = 0;
  int       send_idle_pct = 33;
  int       recv_idle_pct = 46;

  ir_distance_piecewise_linearizer_unit #(.MAX_POINTS(CURVE_SLOTS)) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .raw_sample_i     (raw_sample_i),
    .point_index_i    (point_index_i),
    .point_level_i    (point_level_i),
    .point_distance_i (point_distance_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .scaled_level_o   (scaled_level_o),
    .distance_mm_o    (distance_mm_o),
    .status_o         (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: stalls at the rate of the current idling phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Distance the block should report for one sample, from the model curve.
  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] raw);
    reading_t r;
    int       s, n, k, seg, den, num, d;
    s = (int'(raw) * SCALE_MUL) >> SCALE_SHIFT;
    n = int'(point_count_m);
    if (n < PTS_MIN) n = PTS_MIN;
    if (n > CURVE_SLOTS) n = CURVE_SLOTS;
    if (s > curve_lvl_m[0]) begin
      d = curve_dist_m[0];
      r.status = ST_NEAR;
    end else if (s < curve_lvl_m[n-1]) begin
      d = curve_dist_m[n-1];
      r.status = ST_FAR;
    end else begin
      // first breakpoint at or below the level; k == 0 means level equals
      // the first point, which falls back to segment 0
      k = 0;
      while (k < n - 1 && s < curve_lvl_m[k]) k++;
      seg = (k == 0) ? 0 : k - 1;
      den = curve_lvl_m[seg+1] - curve_lvl_m[seg];
      if (den == 0) begin
        d = curve_dist_m[seg];              // zero-width segment: left distance
      end else begin
        num = (curve_dist_m[seg+1] - curve_dist_m[seg]) * (s - curve_lvl_m[seg]);
        d = curve_dist_m[seg] + num / den;  // int division truncates toward zero
        if (d < 0) d = 0;
        if (d > DIST_MAX) d = DIST_MAX;
      end
      r.status = ST_INTERP;
    end
    r.level    = s[LEVEL_W-1:0];
    r.distance = d[DIST_W-1:0];
    return r;
  endfunction

  // Result checker: every accepted output item against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected item lvl=%0d dist=%0d status=%0d", $time,
                 scaled_level_o, distance_mm_o, status_o);
      end else begin
        want = pending_readings.pop_front();
        if (scaled_level_o !== want.level) begin
          errors++;
          $display("%0t: scaled_level expected %0d actual %0d", $time,
                   want.level, scaled_level_o);
        end
        if (distance_mm_o !== want.distance) begin
          errors++;
          $display("%0t: distance_mm expected %0d actual %0d", $time,
                   want.distance, distance_mm_o);
        end
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, status_o);
        end
      end
    end
  end

  // Send one item; returns at the edge where it was accepted.
  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] raw,
                           input logic [IDX_W-1:0] idx, input logic [LEVEL_W-1:0] lvl,
                           input logic [DIST_W-1:0] dst);
    reading_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    raw_sample_i     <= raw;
    point_index_i    <= idx;
    point_level_i    <= lvl;
    point_distance_i <= dst;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_WRITE) begin
      if (int'(idx) < CURVE_SLOTS) begin
        curve_lvl_m[idx]  = lvl;
        curve_dist_m[idx] = dst;
      end
      r.level    = '0;
      r.distance = '0;
      r.status   = ST_WRITE;
    end else begin
      r = predict_reading(raw);
    end
    pending_readings.push_back(r);
  endtask

  // Unused fields carry random bits so every input bit toggles.
  task automatic send_convert(input logic [SAMPLE_W-1:0] raw);
    send_item(OP_CONVERT, raw, IDX_W'($urandom), LEVEL_W'($urandom), DIST_W'($urandom));
  endtask

  task automatic send_point_write(input int idx, input int lvl, input int dst);
    send_item(OP_WRITE, SAMPLE_W'($urandom), IDX_W'(idx), LEVEL_W'(lvl), DIST_W'(dst));
  endtask

  // Hold the sender until every outstanding result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Point count is only changed with the block idle.
  task automatic set_point_count(input int cnt);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= PTS_W'(cnt);
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    point_count_m  = PTS_W'(cnt);
    @(posedge clk_i);
  endtask

  // Reset curve, 17 points: both clamps, both end points, an interior level.
  task automatic test_default_curve();
    send_convert(10'd0);     // far clamp
    send_convert(10'd61);    // level 29, just past the far point
    send_convert(10'd62);    // level 30, on the last point
    send_convert(10'd400);   // level 195, interior segment
    send_convert(10'd615);   // level 300, on the first point
    send_convert(10'd617);   // level 301, near clamp
    send_convert(10'd1023);  // level 499
  endtask

  // Point count extremes, including values the block saturates.
  task automatic test_point_count_extremes();
    set_point_count(2);
    send_convert(10'd400);   // beyond the second point: far
    send_convert(10'd566);   // level 276, first segment
    set_point_count(0);
    send_convert(10'd566);
    set_point_count(1);
    send_convert(10'd0);
    set_point_count(31);
    send_convert(10'd62);
    set_point_count(17);
  endtask

  // Breakpoint writes: ignored slots, field extremes, two points on one level.
  task automatic test_point_writes();
    send_point_write(31, 511, 4095);   // out of range, ignored
    send_point_write(17, 0, 0);        // first slot past the store, ignored
    send_point_write(16, 511, 4095);
    send_convert(10'd100);             // below the raised far point
    send_point_write(1, 300, 4095);    // same level as point 0
    send_convert(10'd615);             // level 300: still below the raised far point, so far
    send_point_write(1, 270, 40);
    send_point_write(16, 30, 400);
    send_point_write(0, 0, 0);
    send_convert(10'd0);
    send_convert(10'd5);
    send_point_write(0, 300, 30);
  endtask

  // Falling curve with random spacing; repeated levels give flat steps.
  task automatic load_falling_curve();
    int lvl, dst;
    lvl = $urandom_range(499, 280);
    dst = $urandom_range(60);
    for (int i = 0; i < CURVE_SLOTS; i++) begin
      send_point_write(i, lvl, dst);
      lvl -= $urandom_range(30);
      if (lvl < 0) lvl = 0;
      dst += $urandom_range(250);
      if (dst > DIST_MAX) dst = DIST_MAX;
    end
  endtask

  // One random phase: new curve, then mostly conversions with stray writes.
  task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                     input int cnt, input int n_items);
    int lvl, raw;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    set_point_count(cnt);
    load_falling_curve();
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(49) == 0) drain_results();
      if ($urandom_range(99) < 12) begin
        send_point_write(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(16),
                         $urandom_range(511), $urandom_range(4095));
      end else if ($urandom_range(99) < 40) begin
        // land exactly on a breakpoint level where one is reachable
        lvl = curve_lvl_m[$urandom_range(CURVE_SLOTS - 1)];
        raw = (lvl < 500) ? (lvl * 1024 + 499) / 500 : $urandom_range(1023);
        send_convert(SAMPLE_W'(raw));
      end else begin
        send_convert(SAMPLE_W'($urandom_range(1023)));
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    operation_i      <= OP_CONVERT;
    raw_sample_i     <= '0;
    point_index_i    <= '0;
    point_level_i    <= '0;
    point_distance_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_curve();
    test_point_count_extremes();
    test_point_writes();
    test_random_traffic(33, 46, 17, 200);
    test_random_traffic(46, 33, $urandom_range(31), 200);
    test_random_traffic(0, 0, 5, 200);

    drain_results();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
